/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the S-box core.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/gfias_pkg.sv */
// Types, constants and GF(2^w) helper functions for the S-box core.
// No dependencies; imported by gfias_pow_stage and the top level.
`default_nettype none

package gfias_pkg;

   localparam int MAX_WIDTH = 8;
   localparam int IDX_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 4;
   localparam int POLY_W    = MAX_WIDTH + 1;
   localparam int CSR_IDX_W = 3;

   typedef logic [MAX_WIDTH-1:0] elem_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [WIDTH_W-1:0]   width_type;
   typedef logic [POLY_W-1:0]    poly_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_FIELD_WIDTH      = 3'd0;
   localparam csr_idx_type CSR_FIELD_POLY       = 3'd1;
   localparam csr_idx_type CSR_FWD_AFFINE_ROW   = 3'd2;
   localparam csr_idx_type CSR_FWD_AFFINE_CONST = 3'd3;
   localparam csr_idx_type CSR_INV_AFFINE_ROW   = 3'd4;
   localparam csr_idx_type CSR_INV_AFFINE_CONST = 3'd5;

   localparam width_type RST_FIELD_WIDTH      = 4'd8;
   localparam poly_type  RST_FIELD_POLY       = 9'h11b;
   localparam elem_type  RST_FWD_AFFINE_ROW   = 8'd248;
   localparam elem_type  RST_FWD_AFFINE_CONST = 8'd99;
   localparam elem_type  RST_INV_AFFINE_ROW   = 8'd82;
   localparam elem_type  RST_INV_AFFINE_CONST = 8'd5;

   localparam width_type MIN_FIELD_WIDTH = 4'd2;
   localparam width_type MAX_FIELD_WIDTH = width_type'(MAX_WIDTH);

   localparam logic CMD_FWD = 1'b0;
   localparam logic CMD_INV = 1'b1;

   typedef struct packed {
      logic     cmd;
      elem_type sq;
      elem_type res;
   } stage_type;

   function automatic elem_type width_mask(input width_type w);
      elem_type m;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         m[i] = (i < int'(w));
      end
      return m;
   endfunction

   function automatic elem_type gf_mul(input elem_type a, input elem_type b,
                                       input width_type w, input elem_type low);
      elem_type m;
      elem_type aa;
      elem_type acc;
      logic     top;
      m   = width_mask(w);
      aa  = a & m;
      acc = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         if (i < int'(w)) begin
            if (b[i]) begin
               acc = acc ^ aa;
            end
            top = aa[idx_type'(w - width_type'(1))];
            aa  = ((aa << 1) & m) ^ (top ? low : elem_type'(0));
         end
      end
      return acc & m;
   endfunction

   function automatic elem_type affine(input elem_type x, input elem_type row,
                                       input elem_type cst, input width_type w);
      elem_type m;
      elem_type r;
      elem_type xx;
      elem_type res;
      elem_type wrap;
      m    = width_mask(w);
      r    = row & m;
      xx   = x & m;
      res  = '0;
      wrap = elem_type'(1) << (w - width_type'(1));
      for (int i = 0; i < MAX_WIDTH; i++) begin
         if (i < int'(w)) begin
            res[idx_type'(int'(w) - 1 - i)] = ^(r & xx);
            r = ((r >> 1) | (r[0] ? wrap : elem_type'(0))) & m;
         end
      end
      return (res ^ cst) & m;
   endfunction

endpackage

`default_nettype wire

/* sv/gfias_pow_stage.sv */
// One register stage of the field inversion chain: squares the running power
// and, while the step is below the field width, folds it into the running product. Depends on gfias_pkg.
`default_nettype none

module gfias_pow_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gfias_pkg::idx_type   step,
   input  wire gfias_pkg::width_type width,
   input  wire gfias_pkg::elem_type  poly_low,
   input  wire logic                 in_valid,
   input  wire gfias_pkg::stage_type in_data,
   output logic                      up_ready,
   input  wire logic                 down_ready,
   output logic                      out_valid,
   output gfias_pkg::stage_type      out_data
);
   import gfias_pkg::*;

   logic      load;
   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;

   assign load     = !valid_ff || down_ready;
   assign up_ready = load;
   assign valid_in = load ? in_valid : valid_ff;

   always_comb begin
      data_in.cmd = in_data.cmd;
      data_in.sq  = gf_mul(in_data.sq, in_data.sq, width, poly_low);
      if (width_type'(step) < width) begin
         data_in.res = gf_mul(in_data.res, in_data.sq, width, poly_low);
      end else begin
         data_in.res = in_data.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* sv/gf_inverse_affine_sbox_core.sv */
// Top level of the configurable GF(2^w) S-box with forward and inverse affine maps.
// Depends on gfias_pkg, gfias_pow_stage and assert_macros.svh.
//
//   Channel  Direction  Handshake          Payload
//   req      in         valid / stall      cmd, value
//   rsp      out        valid / stall      result
//   csr      in         valid / ready      index, data
//
// One beat enters per cycle while req_stall is low; each beat passes through the input
// stage, the first squaring, seven multiply stages of the inversion chain and the
// output affine stage.
// Reset is synchronous; it clears the valid bits and returns the configuration
// registers to their reset values.
// A stall holds only the stages that are full; bubbles close up behind it.
`default_nettype none

module gf_inverse_affine_sbox_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_cmd,
   input  wire gfias_pkg::elem_type    req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output gfias_pkg::elem_type         rsp_result,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire gfias_pkg::csr_idx_type csr_index,
   input  wire gfias_pkg::poly_type    csr_data
);
   import gfias_pkg::*;

   `include "assert_macros.svh"

   localparam int LAST = MAX_WIDTH - 1;

   width_type field_width_ff;
   poly_type  field_poly_ff;
   elem_type  fwd_row_ff;
   elem_type  fwd_const_ff;
   elem_type  inv_row_ff;
   elem_type  inv_const_ff;

   width_type eff_width;
   elem_type  field_mask;
   elem_type  poly_low;

   logic      in_valid_ff;
   logic      in_cmd_ff;
   elem_type  in_x_ff;
   elem_type  in_x_in;
   logic      in_load;

   logic      first_valid_ff;
   stage_type first_data_ff;
   stage_type first_data_in;

   logic      pipe_valid [0:LAST];
   stage_type pipe_data  [0:LAST];
   logic      pipe_ready [0:LAST];

   logic      out_ready;
   logic      rsp_valid_ff;
   elem_type  rsp_result_ff;
   elem_type  rsp_result_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= RST_FIELD_WIDTH;
         field_poly_ff  <= RST_FIELD_POLY;
         fwd_row_ff     <= RST_FWD_AFFINE_ROW;
         fwd_const_ff   <= RST_FWD_AFFINE_CONST;
         inv_row_ff     <= RST_INV_AFFINE_ROW;
         inv_const_ff   <= RST_INV_AFFINE_CONST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FIELD_WIDTH:      field_width_ff <= csr_data[WIDTH_W-1:0];
            CSR_FIELD_POLY:       field_poly_ff  <= csr_data;
            CSR_FWD_AFFINE_ROW:   fwd_row_ff     <= csr_data[MAX_WIDTH-1:0];
            CSR_FWD_AFFINE_CONST: fwd_const_ff   <= csr_data[MAX_WIDTH-1:0];
            CSR_INV_AFFINE_ROW:   inv_row_ff     <= csr_data[MAX_WIDTH-1:0];
            CSR_INV_AFFINE_CONST: inv_const_ff   <= csr_data[MAX_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      priority if (field_width_ff < MIN_FIELD_WIDTH) begin
         eff_width = MIN_FIELD_WIDTH;
      end else if (field_width_ff > MAX_FIELD_WIDTH) begin
         eff_width = MAX_FIELD_WIDTH;
      end else begin
         eff_width = field_width_ff;
      end
   end

   assign field_mask = width_mask(eff_width);
   assign poly_low   = field_poly_ff[MAX_WIDTH-1:0] & field_mask;

   // Input stage: masking and, for the inverse S-box, the inverse affine map.
   assign in_load   = !in_valid_ff || pipe_ready[0];
   assign req_stall = !in_load;

   always_comb begin
      if (req_cmd == CMD_INV) begin
         in_x_in = affine(req_value, inv_row_ff, inv_const_ff, eff_width);
      end else begin
         in_x_in = req_value & field_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_cmd_ff <= req_cmd;
         in_x_ff   <= in_x_in;
      end
   end

   // First squaring; the running product starts at one.
   assign pipe_ready[0] = !first_valid_ff || pipe_ready[1];

   always_comb begin
      first_data_in.cmd = in_cmd_ff;
      first_data_in.sq  = gf_mul(in_x_ff, in_x_ff, eff_width, poly_low);
      first_data_in.res = elem_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_valid_ff <= 1'b0;
      end else if (pipe_ready[0]) begin
         first_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_ready[0] && in_valid_ff) begin
         first_data_ff <= first_data_in;
      end
   end

   assign pipe_valid[0] = first_valid_ff;
   assign pipe_data[0]  = first_data_ff;

   for (genvar j = 1; j <= LAST; j++) begin : g_pow
      logic down_ready;

      if (j == LAST) begin : g_tail
         assign down_ready = out_ready;
      end else begin : g_mid
         assign down_ready = pipe_ready[j+1];
      end

      gfias_pow_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .step       (idx_type'(j)),
         .width      (eff_width),
         .poly_low   (poly_low),
         .in_valid   (pipe_valid[j-1]),
         .in_data    (pipe_data[j-1]),
         .up_ready   (pipe_ready[j]),
         .down_ready (down_ready),
         .out_valid  (pipe_valid[j]),
         .out_data   (pipe_data[j])
      );
   end

   // Output stage: forward affine map for the forward S-box.
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (pipe_data[LAST].cmd == CMD_FWD) begin
         rsp_result_in = affine(pipe_data[LAST].res, fwd_row_ff, fwd_const_ff, eff_width);
      end else begin
         rsp_result_in = pipe_data[LAST].res & field_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= pipe_valid[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && pipe_valid[LAST]) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   `ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall,
      in_valid_ff && first_valid_ff && pipe_valid[LAST] && rsp_valid_ff)
   `ASSERT_IMPLY(a_result_masked, clock, reset, rsp_valid_ff,
      (rsp_result_ff & ~field_mask) == elem_type'(0))
   `ASSERT_NEXT(a_input_advances, clock, reset, in_valid_ff && pipe_ready[0],
      first_valid_ff)

endmodule

`default_nettype wire

/* tb/gf_inverse_affine_sbox_core_tb.sv */
// Self-checking testbench for gf_inverse_affine_sbox_core: forward and inverse S-box beats
// are checked against an in-bench GF(2^w) predictor across many register settings.
// Depends on gfias_pkg and the core; drives random idling and output back-pressure.
`timescale 1ns / 1ps

module gf_inverse_affine_sbox_core_tb;
   import gfias_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = MAX_WIDTH + 10;

   typedef struct {
      logic     cmd;
      elem_type value;
      elem_type result;
   } substitution_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   elem_type    req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   elem_type    rsp_result;
   logic        csr_valid;
   logic        csr_ready;
   csr_idx_type csr_index;
   poly_type    csr_data;

   width_type sbox_width_reg;
   poly_type  sbox_poly_reg;
   elem_type  fwd_row_reg;
   elem_type  fwd_const_reg;
   elem_type  inv_row_reg;
   elem_type  inv_const_reg;

   substitution_type pending_results[$];
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   bit               req_gaps_on = 1'b1;
   bit               rsp_stalls_on = 1'b1;
   int               rsp_hold_len = 0;

   gf_inverse_affine_sbox_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned clamp_width(input width_type raw);
      int unsigned w;
      w = 32'(raw);
      if (w < 32'(MIN_FIELD_WIDTH)) w = 32'(MIN_FIELD_WIDTH);
      if (w > 32'(MAX_FIELD_WIDTH)) w = 32'(MAX_FIELD_WIDTH);
      return w;
   endfunction

   function automatic elem_type lane_mask(input int unsigned w);
      return elem_type'((32'd1 << w) - 32'd1);
   endfunction

   function automatic elem_type field_product(input elem_type a, input elem_type b,
                                              input int unsigned w);
      elem_type m;
      elem_type low;
      elem_type acc;
      m   = lane_mask(w);
      low = sbox_poly_reg[MAX_WIDTH-1:0] & m;
      acc = '0;
      for (int i = MAX_WIDTH - 1; i >= 0; i--) begin
         if (i < w) begin
            acc = acc[w-1] ? (((acc << 1) & m) ^ low) : ((acc << 1) & m);
            if (b[i]) acc = acc ^ (a & m);
         end
      end
      return acc;
   endfunction

   // Raises x to 2^w - 2, which is the field inverse for an irreducible polynomial.
   function automatic elem_type field_inverse(input elem_type x, input int unsigned w);
      elem_type    base;
      elem_type    acc;
      int unsigned e;
      base = x & lane_mask(w);
      acc  = elem_type'(1);
      e    = (32'd1 << w) - 32'd2;
      while (e != 0) begin
         if (e & 1) acc = field_product(acc, base, w);
         base = field_product(base, base, w);
         e    = e >> 1;
      end
      return acc;
   endfunction

   // Bit j of the product uses the first row rotated right by w-1-j within w bits.
   function automatic elem_type affine_map(input elem_type x, input elem_type row,
                                           input elem_type cst, input int unsigned w);
      elem_type    m;
      elem_type    prod;
      int unsigned k;
      logic        acc_bit;
      m    = lane_mask(w);
      prod = '0;
      for (int j = 0; j < w; j++) begin
         k       = w - 1 - j;
         acc_bit = 1'b0;
         for (int b = 0; b < w; b++) begin
            acc_bit = acc_bit ^ (row[(b + k) % w] & x[b]);
         end
         prod[j] = acc_bit;
      end
      return (prod ^ cst) & m;
   endfunction

   function automatic elem_type predict_substitution(input logic cmd, input elem_type value);
      int unsigned w;
      elem_type    x;
      w = clamp_width(sbox_width_reg);
      x = value & lane_mask(w);
      if (cmd == CMD_FWD) begin
         return affine_map(field_inverse(x, w), fwd_row_reg, fwd_const_reg, w);
      end
      return field_inverse(affine_map(x, inv_row_reg, inv_const_reg, w), w);
   endfunction

   function automatic poly_type irreducible_for(input int unsigned w);
      unique case (w)
         2: return 9'h007;
         3: return 9'h00b;
         4: return 9'h013;
         5: return 9'h025;
         6: return 9'h043;
         7: return 9'h083;
         default: return 9'h11b;
      endcase
   endfunction

   task automatic report_mismatch(input string text);
      $display("%0t: mismatch: %s", $time, text);
      mismatch_count++;
   endtask

   task automatic send_substitution(input logic cmd, input elem_type value);
      substitution_type beat;
      @(negedge clock);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd   = cmd;
      req_value = value;
      do @(posedge clock); while (req_stall);
      beat.cmd    = cmd;
      beat.value  = value;
      beat.result = predict_substitution(cmd, value);
      pending_results.push_back(beat);
   endtask

   task automatic send_random_substitution();
      send_substitution(1'($urandom_range(0, 1)), elem_type'($urandom_range(0, 255)));
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input poly_type data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      unique case (idx)
         CSR_FIELD_WIDTH:      sbox_width_reg = data[WIDTH_W-1:0];
         CSR_FIELD_POLY:       sbox_poly_reg  = data;
         CSR_FWD_AFFINE_ROW:   fwd_row_reg    = data[MAX_WIDTH-1:0];
         CSR_FWD_AFFINE_CONST: fwd_const_reg  = data[MAX_WIDTH-1:0];
         CSR_INV_AFFINE_ROW:   inv_row_reg    = data[MAX_WIDTH-1:0];
         CSR_INV_AFFINE_CONST: inv_const_reg  = data[MAX_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_registers(input poly_type w, input poly_type poly,
                                 input poly_type fwd_row, input poly_type fwd_const,
                                 input poly_type inv_row, input poly_type inv_const);
      wait_until_drained();
      write_register(CSR_FIELD_WIDTH, w);
      write_register(CSR_FIELD_POLY, poly);
      write_register(CSR_FWD_AFFINE_ROW, fwd_row);
      write_register(CSR_FWD_AFFINE_CONST, fwd_const);
      write_register(CSR_INV_AFFINE_ROW, inv_row);
      write_register(CSR_INV_AFFINE_CONST, inv_const);
   endtask

   task automatic load_random_registers();
      width_type   w;
      int unsigned eff;
      poly_type    keep;
      poly_type    poly;
      w    = ($urandom_range(0, 4) == 0) ? width_type'($urandom_range(0, 15))
                                         : width_type'($urandom_range(2, 8));
      eff  = clamp_width(w);
      poly = poly_type'($urandom_range(0, 511));
      if ($urandom_range(0, 2) != 0) begin
         keep = poly_type'((32'd1 << (eff + 1)) - 32'd1);
         poly = (poly & ~keep) | irreducible_for(eff);
      end
      load_registers(poly_type'({$urandom_range(0, 31), w}), poly,
                     poly_type'($urandom_range(0, 511)), poly_type'($urandom_range(0, 511)),
                     poly_type'($urandom_range(0, 511)), poly_type'($urandom_range(0, 511)));
   endtask

   task automatic test_default_sbox();
      send_substitution(CMD_FWD, 8'h00);
      send_substitution(CMD_FWD, 8'h01);
      send_substitution(CMD_FWD, 8'hff);
      send_substitution(CMD_FWD, 8'h53);
      send_substitution(CMD_INV, 8'h63);
      send_substitution(CMD_INV, 8'h00);
      send_substitution(CMD_INV, 8'hff);
      send_substitution(CMD_INV, 8'h7c);
   endtask

   task automatic test_register_extremes();
      // Width below the minimum, wide row and constant, upper value bits ignored.
      load_registers(9'd0, 9'h007, 9'h1ff, 9'h000, 9'h000, 9'h1ff);
      send_substitution(CMD_FWD, 8'hfc);
      send_substitution(CMD_INV, 8'h03);
      send_substitution(CMD_FWD, 8'h00);
      // Width above the maximum with every register bit set.
      load_registers(9'h1ff, 9'h1ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff);
      send_substitution(CMD_FWD, 8'hff);
      send_substitution(CMD_INV, 8'h00);
      send_substitution(CMD_INV, 8'haa);
      // Width of one and a zero polynomial, which is reducible.
      load_registers(9'd1, 9'h000, 9'h002, 9'h001, 9'h001, 9'h002);
      send_substitution(CMD_FWD, 8'h01);
      send_substitution(CMD_INV, 8'h02);
      send_substitution(CMD_FWD, 8'h03);
      // Full width with x^8 as the polynomial and zero affine terms.
      load_registers(9'd8, 9'h100, 9'h000, 9'h000, 9'h000, 9'h000);
      send_substitution(CMD_FWD, 8'h02);
      send_substitution(CMD_INV, 8'h80);
      load_registers(9'd4, 9'h013, 9'h00f, 9'h006, 9'h00b, 9'h1f3);
      send_substitution(CMD_FWD, 8'h00);
      send_substitution(CMD_INV, 8'h00);
      send_substitution(CMD_FWD, 8'hf7);
      // Bits above the width set and the leading bit clear in the polynomial.
      load_registers(9'd5, 9'h1c5, 9'h0b4, 9'h13c, 9'h049, 9'h0a5);
      send_substitution(CMD_FWD, 8'h1f);
      send_substitution(CMD_INV, 8'he0);
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 8; phase++) begin
         load_random_registers();
         req_gaps_on   = 1'b1;
         rsp_stalls_on = 1'b1;
         repeat (140) send_random_substitution();
      end
   endtask

   task automatic test_output_hold_off();
      wait_until_drained();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      rsp_hold_len  = 100;
      repeat (60) send_random_substitution();
   endtask

   task automatic test_full_rate();
      load_registers(poly_type'(RST_FIELD_WIDTH), RST_FIELD_POLY,
                     poly_type'(RST_FWD_AFFINE_ROW), poly_type'(RST_FWD_AFFINE_CONST),
                     poly_type'(RST_INV_AFFINE_ROW), poly_type'(RST_INV_AFFINE_CONST));
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      repeat (150) send_random_substitution();
      load_random_registers();
      repeat (150) send_random_substitution();
      wait_until_drained();
   endtask

   initial begin : rsp_stall_driver
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len != 0) begin
            hold         = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_stall    = 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_checker
      substitution_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %02h with no beat outstanding", rsp_result));
         end else begin
            want = pending_results.pop_front();
            if (rsp_result !== want.result) begin
               report_mismatch($sformatf("cmd %0d value %02h gave result %02h, expected %02h",
                                         want.cmd, want.value, rsp_result, want.result));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("gf_inverse_affine_sbox_core_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_FWD;
      req_value      = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_FIELD_WIDTH;
      csr_data       = '0;
      sbox_width_reg = RST_FIELD_WIDTH;
      sbox_poly_reg  = RST_FIELD_POLY;
      fwd_row_reg    = RST_FWD_AFFINE_ROW;
      fwd_const_reg  = RST_FWD_AFFINE_CONST;
      inv_row_reg    = RST_INV_AFFINE_ROW;
      inv_const_reg  = RST_INV_AFFINE_CONST;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_default_sbox();
      test_register_extremes();
      test_random_settings();
      test_output_hold_off();
      test_full_rate();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("gf_inverse_affine_sbox_core_tb OK");
      end else begin
         $display("gf_inverse_affine_sbox_core_tb NOT OK");
      end
      $finish;
   end

endmodule

/* gf_inverse_affine_sbox_core.f */
+incdir+sv
sv/gfias_pkg.sv
sv/gfias_pow_stage.sv
sv/gf_inverse_affine_sbox_core.sv
tb/gf_inverse_affine_sbox_core_tb.sv
